// ===== rtl/max_heap_priority_queue_core_defines.svh =====
// Assertion macros for the max-heap priority queue RTL
`ifndef MAX_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// condition holds at every clock edge out of reset
`define MHPQ_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("mhpq: invariant violated");

// antecedent implies consequent in the same cycle
`define MHPQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mhpq: implication violated");

// antecedent implies consequent in the next cycle
`define MHPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mhpq: next-cycle check violated");

`else

`define MHPQ_ASSERT(label, cond)
`define MHPQ_ASSERT_IMPL(label, ante, cons)
`define MHPQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/mhpq_pkg.sv =====
// Shared types, codes and helpers for the max-heap priority queue
`timescale 1ns / 1ps

package mhpq_pkg;

  localparam int VALUE_W     = 32;
  localparam int COUNT_OUT_W = 9;
  localparam int STATUS_W    = 2;
  localparam int OUT_BITS    = 2 * VALUE_W + COUNT_OUT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_LOAD,
    S_RUN,
    S_RESULT
  } state_t;

  // token control handed from one level cell to the next
  typedef struct packed {
    logic valid;
    op_t  op;
  } tok_ctl_t;

  // index of the highest set bit (zero for zero)
  function automatic logic [4:0] msb_index(input logic [31:0] x);
    logic [4:0] idx;
    idx = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/max_heap_priority_queue_core.sv =====
// Top level of the max-heap priority queue: controller, cell chain and ports
`timescale 1ns / 1ps
`include "max_heap_priority_queue_core_defines.svh"

// Binary max-heap of signed 32-bit values built as a chain of level cells,
// one cell per tree level, each owning that level's nodes in a small memory.
// Each input transaction either inserts a value (tuser 0) or deletes the
// maximum (tuser 1) and yields one result transaction with the removed value,
// the new top, the entry count and a status. An insert walks from the root
// down the path to the new slot, keeping the larger value at each level. A
// delete first reads the last entry, then sifts it down one level per cycle
// until it settles. The one-level-per-cycle pace is set by the registered
// read of each cell's memory feeding that level's compare. A delete on an
// empty heap or an insert into a full one flags the status and leaves the
// heap alone; these, like deleting the only entry, go straight to the result
// without a sift. The result register lets a new transaction be accepted
// while the previous result still waits. Storage needs no clearing after
// reset.
module max_heap_priority_queue_core #(
  parameter int HEAP_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mhpq_pkg::VALUE_W-1:0]        in_tdata,  // [31:0] value
  input  logic [0:0]                          in_tuser,  // [0] operation
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] removed_value, [63:32] top_value, [72:64] entry_count, rest zero
  output logic [mhpq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [mhpq_pkg::STATUS_W-1:0]       out_tuser  // [1:0] status
);

  import mhpq_pkg::*;

  localparam int NL  = $clog2(HEAP_DEPTH + 1);
  localparam int CW  = NL;
  localparam int PW  = NL - 1;
  localparam int LVW = $clog2(NL);

  state_t  state_r, state_nxt;

  logic [CW-1:0]  count_r;
  logic [CW-1:0]  n_r;
  logic [LVW-1:0] lvl_r;
  logic [LVW-1:0] fetch_lvl_r;
  logic [PW-1:0]  fetch_pos_r;
  op_t            op_r;
  value_t         v_r;
  value_t         root_r;
  value_t         res_removed_r;
  status_t        res_status_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [STATUS_W-1:0]    out_tuser_r;

  logic    in_fire;
  logic    out_free;
  logic    fetch_en;
  logic    launch;
  op_t     in_op;
  value_t  in_val;
  value_t  top_val;

  // cell chain wiring
  tok_ctl_t      tok_ctl [NL];
  value_t        tok_val [NL];
  logic [PW-1:0] tok_pos [NL];
  logic          req_en  [NL];
  logic [PW-1:0] req_pos [NL];
  value_t        rd_a    [NL];
  value_t        rd_b    [NL];
  value_t        wr_val  [NL];
  logic [NL-1:0] wr_en_vec;
  logic [NL-1:0] done_vec;

  assign in_op    = op_t'(in_tuser[0]);
  assign in_val   = value_t'(in_tdata);
  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and control outputs
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    fetch_en  = 1'b0;
    launch    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          if (in_op == OP_INSERT) begin
            state_nxt = (count_r == CW'(HEAP_DEPTH)) ? S_RESULT : S_LOAD;
          end else if (count_r <= CW'(1)) begin
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        fetch_en  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        launch    = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (|done_vec) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // operation setup on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_fire) begin
      if (in_op == OP_INSERT) begin
        if (count_r != CW'(HEAP_DEPTH)) begin
          count_r <= count_r + 1'b1;
        end
      end else if (count_r != '0) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_op;
      v_r  <= in_val;
      if (in_op == OP_INSERT) begin
        n_r           <= count_r + 1'b1;
        lvl_r         <= LVW'(msb_index(32'(count_r + 1'b1)));
        res_removed_r <= '0;
        res_status_r  <= (count_r == CW'(HEAP_DEPTH)) ? STATUS_FULL : STATUS_OK;
      end else begin
        n_r         <= count_r - 1'b1;
        fetch_lvl_r <= LVW'(msb_index(32'(count_r)));
        fetch_pos_r <= PW'(count_r);
        if (count_r == '0) begin
          res_removed_r <= '0;
          res_status_r  <= STATUS_EMPTY;
        end else begin
          res_removed_r <= root_r;
          res_status_r  <= STATUS_OK;
        end
      end
    end
  end

  // root shadow, follows every write to the top level
  always_ff @(posedge clk) begin
    if (wr_en_vec[0]) begin
      root_r <= wr_val[0];
    end
  end

  // result register
  assign top_val = (count_r != '0) ? root_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_RESULT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RESULT && out_free) begin
      out_tdata_r <= {{OUT_PAD_W{1'b0}}, COUNT_OUT_W'(count_r), top_val, res_removed_r};
      out_tuser_r <= res_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // token into the root level
  assign tok_ctl[0].valid = launch;
  assign tok_ctl[0].op    = op_r;
  assign tok_val[0]       = (op_r == OP_DELETE) ? rd_a[fetch_lvl_r] : v_r;
  assign tok_pos[0]       = '0;
  assign req_en[0]        = 1'b0;
  assign req_pos[0]       = '0;

  // one cell per tree level
  for (genvar g = 0; g < NL; g++) begin : g_level
    if (g < NL - 1) begin : g_inner
      mhpq_cell #(
        .NUM_LEVELS (NL),
        .LEVEL      (g)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .tok_in_ctl  (tok_ctl[g]),
        .tok_in_val  (tok_val[g]),
        .tok_in_pos  (tok_pos[g]),
        .tgt_n       (n_r),
        .tgt_lvl     (lvl_r),
        .fetch_en    (fetch_en),
        .fetch_lvl   (fetch_lvl_r),
        .fetch_pos   (fetch_pos_r),
        .par_rd_en   (req_en[g]),
        .par_rd_pos  (req_pos[g]),
        .child_a     (rd_a[g+1]),
        .child_b     (rd_b[g+1]),
        .rd_a_r      (rd_a[g]),
        .rd_b_r      (rd_b[g]),
        .req_rd_en   (req_en[g+1]),
        .req_rd_pos  (req_pos[g+1]),
        .tok_out_ctl (tok_ctl[g+1]),
        .tok_out_val (tok_val[g+1]),
        .tok_out_pos (tok_pos[g+1]),
        .wr_en       (wr_en_vec[g]),
        .wr_val      (wr_val[g]),
        .done        (done_vec[g])
      );
    end else begin : g_last
      mhpq_cell #(
        .NUM_LEVELS (NL),
        .LEVEL      (g)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .tok_in_ctl  (tok_ctl[g]),
        .tok_in_val  (tok_val[g]),
        .tok_in_pos  (tok_pos[g]),
        .tgt_n       (n_r),
        .tgt_lvl     (lvl_r),
        .fetch_en    (fetch_en),
        .fetch_lvl   (fetch_lvl_r),
        .fetch_pos   (fetch_pos_r),
        .par_rd_en   (req_en[g]),
        .par_rd_pos  (req_pos[g]),
        .child_a     ('0),
        .child_b     ('0),
        .rd_a_r      (rd_a[g]),
        .rd_b_r      (rd_b[g]),
        .req_rd_en   (),
        .req_rd_pos  (),
        .tok_out_ctl (),
        .tok_out_val (),
        .tok_out_pos (),
        .wr_en       (wr_en_vec[g]),
        .wr_val      (wr_val[g]),
        .done        (done_vec[g])
      );
    end
  end

  // checks
  `MHPQ_ASSERT(a_count_bound, count_r <= CW'(HEAP_DEPTH))
  `MHPQ_ASSERT(a_single_done, $onehot0(done_vec))
  `MHPQ_ASSERT_IMPL(a_done_in_run, |done_vec, state_r == S_RUN)
  `MHPQ_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)

endmodule

// ===== rtl/mhpq_cell.sv =====
// One heap level: node storage for the level plus its sift step
`timescale 1ns / 1ps

module mhpq_cell #(
  parameter int NUM_LEVELS = 9,
  parameter int LEVEL      = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // token from the level above
  input  mhpq_pkg::tok_ctl_t            tok_in_ctl,
  input  mhpq_pkg::value_t              tok_in_val,
  input  logic [NUM_LEVELS-2:0]         tok_in_pos,
  // per-operation context broadcast by the controller
  input  logic [NUM_LEVELS-1:0]         tgt_n,
  input  logic [$clog2(NUM_LEVELS)-1:0] tgt_lvl,
  // last-entry fetch
  input  logic                          fetch_en,
  input  logic [$clog2(NUM_LEVELS)-1:0] fetch_lvl,
  input  logic [NUM_LEVELS-2:0]         fetch_pos,
  // child-pair read request from the level above
  input  logic                          par_rd_en,
  input  logic [NUM_LEVELS-2:0]         par_rd_pos,
  // child pair data from the level below
  input  mhpq_pkg::value_t              child_a,
  input  mhpq_pkg::value_t              child_b,
  // registered read data
  output mhpq_pkg::value_t              rd_a_r,
  output mhpq_pkg::value_t              rd_b_r,
  // child-pair read request to the level below
  output logic                          req_rd_en,
  output logic [NUM_LEVELS-2:0]         req_rd_pos,
  // token to the level below
  output mhpq_pkg::tok_ctl_t            tok_out_ctl,
  output mhpq_pkg::value_t              tok_out_val,
  output logic [NUM_LEVELS-2:0]         tok_out_pos,
  // node write (watched at the root to track the top)
  output logic                          wr_en,
  output mhpq_pkg::value_t              wr_val,
  output logic                          done
);

  import mhpq_pkg::*;

  localparam int PW    = NUM_LEVELS - 1;
  localparam int CW    = NUM_LEVELS;
  localparam int LVW   = $clog2(NUM_LEVELS);
  localparam int MEM_D = 1 << LEVEL;
  localparam int IW    = (LEVEL > 0) ? LEVEL : 1;
  localparam logic [IW-1:0] ADDR_MASK = IW'(MEM_D - 1);

  value_t mem [MEM_D];

  logic          busy_r;
  op_t           op_r;
  value_t        v_r;
  logic [IW-1:0] p_r;

  logic [IW-1:0] addr_a;
  logic [IW-1:0] addr_b;
  logic [PW:0]   cpos;
  logic          fetch_hit;
  logic [LVW-1:0] bidx;
  logic          nbit;
  logic          is_tgt;
  logic [CW:0]   lchild_n;
  logic          left_ok;
  logic          right_ok;
  logic          pick_right;
  value_t        pick_val;

  // read address select: own slot, child pair, or fetch
  always_comb begin
    cpos      = {par_rd_pos, 1'b0};
    fetch_hit = fetch_en && (fetch_lvl == LVW'(LEVEL));
    addr_a    = '0;
    addr_b    = '0;
    if (tok_in_ctl.valid) begin
      addr_a = tok_in_pos[IW-1:0] & ADDR_MASK;
    end else if (par_rd_en) begin
      addr_a = cpos[IW-1:0] & ADDR_MASK;
      addr_b = (cpos[IW-1:0] | IW'(1)) & ADDR_MASK;
    end else if (fetch_hit) begin
      addr_a = fetch_pos[IW-1:0] & ADDR_MASK;
    end
  end

  // child read request travels with the delete token
  assign req_rd_en  = tok_in_ctl.valid && (tok_in_ctl.op == OP_DELETE);
  assign req_rd_pos = tok_in_pos;

  // level storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[p_r & ADDR_MASK] <= wr_val;
    end
    rd_a_r <= mem[addr_a];
    rd_b_r <= mem[addr_b];
  end

  // token capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= tok_in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in_ctl.valid) begin
      op_r <= tok_in_ctl.op;
      v_r  <= tok_in_val;
      p_r  <= tok_in_pos[IW-1:0] & ADDR_MASK;
    end
  end

  // path and child bookkeeping
  always_comb begin
    is_tgt     = (tgt_lvl == LVW'(LEVEL));
    bidx       = tgt_lvl - LVW'(LEVEL + 1);
    nbit       = tgt_n[bidx];
    lchild_n   = ((CW+1)'(1) << (LEVEL + 1)) | (CW+1)'({p_r, 1'b0});
    left_ok    = lchild_n <= {1'b0, tgt_n};
    right_ok   = lchild_n < {1'b0, tgt_n};
    pick_right = right_ok && (child_b > child_a);
    pick_val   = pick_right ? child_b : child_a;
  end

  // sift step: insert pushes the smaller value down the path,
  // delete pulls the larger child up while it beats the moving value
  always_comb begin
    wr_en             = 1'b0;
    wr_val            = v_r;
    tok_out_ctl.valid = 1'b0;
    tok_out_ctl.op    = op_r;
    tok_out_val       = v_r;
    tok_out_pos       = '0;
    done              = 1'b0;
    if (busy_r) begin
      if (op_r == OP_INSERT) begin
        if (is_tgt) begin
          wr_en = 1'b1;
          done  = 1'b1;
        end else begin
          tok_out_ctl.valid = 1'b1;
          tok_out_pos       = PW'({p_r, nbit});
          if (v_r > rd_a_r) begin
            wr_en       = 1'b1;
            tok_out_val = rd_a_r;
          end
        end
      end else begin
        wr_en = 1'b1;
        if (left_ok && (pick_val > v_r)) begin
          wr_val            = pick_val;
          tok_out_ctl.valid = 1'b1;
          tok_out_pos       = PW'({p_r, pick_right});
        end else begin
          done = 1'b1;
        end
      end
    end
  end

endmodule

// ===== tb/max_heap_priority_queue_core_tb.sv =====
// Self-checking testbench for the max-heap priority queue core
`timescale 1ns / 1ps

module max_heap_priority_queue_core_tb;
  import mhpq_pkg::*;

  localparam int DEPTH        = 256;
  localparam int ITEM_TARGET  = 1350;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT      = 300;
  localparam int DRAIN_CYCLES = 40;

  // one command as the sender offers it
  typedef struct packed {
    op_t    op;
    value_t value;
  } heap_cmd_t;

  // one result as the block should report it
  typedef struct packed {
    value_t            removed;
    value_t            top;
    logic [8:0]        count;
    status_t           status;
  } heap_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [VALUE_W-1:0]     in_tdata = '0;
  logic [0:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;

  heap_cmd_t    cmd_q[$];
  heap_result_t expected_q[$];

  // shadow heap used for prediction
  value_t heap_mem[DEPTH];
  int     heap_fill = 0;

  // fill level tracked while building the stimulus
  int gen_fill = 0;

  int mismatch_count = 0;
  int results_seen = 0;
  int tx_gap_left = 0;
  int tx_burst_left = 0;
  int rx_stall_left = 0;
  int rx_burst_left = 0;
  logic rx_hold = 1'b0;
  logic hold_done = 1'b0;
  int hold_count = 0;

  max_heap_priority_queue_core #(
    .HEAP_DEPTH(DEPTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #6 clk = ~clk;

  // apply one command to the shadow heap and return what the block should report
  function automatic heap_result_t apply_heap_op(op_t op, value_t v);
    heap_result_t r;
    int pos;
    int left;
    int right;
    int pick;
    logic settled;
    value_t tmp;
    r = '0;
    r.status = STATUS_OK;
    if (op == OP_INSERT) begin
      if (heap_fill >= DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        heap_mem[heap_fill] = v;
        pos = heap_fill;
        heap_fill++;
        // sift up while strictly larger than the parent
        while (pos > 0 && heap_mem[(pos - 1) / 2] < heap_mem[pos]) begin
          tmp = heap_mem[pos];
          heap_mem[pos] = heap_mem[(pos - 1) / 2];
          heap_mem[(pos - 1) / 2] = tmp;
          pos = (pos - 1) / 2;
        end
      end
    end else begin
      if (heap_fill == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.removed = heap_mem[0];
        heap_fill--;
        heap_mem[0] = heap_mem[heap_fill];
        pos = 0;
        settled = 1'b0;
        // sift down toward the larger child, left on a tie
        while (!settled) begin
          left = 2 * pos + 1;
          right = left + 1;
          if (left >= heap_fill) begin
            settled = 1'b1;
          end else begin
            pick = left;
            if (right < heap_fill && heap_mem[right] > heap_mem[left]) begin
              pick = right;
            end
            if (heap_mem[pick] > heap_mem[pos]) begin
              tmp = heap_mem[pick];
              heap_mem[pick] = heap_mem[pos];
              heap_mem[pos] = tmp;
              pos = pick;
            end else begin
              settled = 1'b1;
            end
          end
        end
      end
    end
    r.top = (heap_fill != 0) ? heap_mem[0] : '0;
    r.count = 9'(heap_fill);
    return r;
  endfunction

  // idle length: mostly short, now and then long
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // value mix: full range, a narrow band for duplicates, and the extremes
  function automatic value_t draw_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return value_t'($urandom);
    end else if (r < 8) begin
      return value_t'($urandom_range(0, 8)) - value_t'(4);
    end
    case ($urandom_range(0, 3))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return -32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  task automatic queue_cmd(op_t op, value_t v);
    heap_cmd_t c;
    c.op = op;
    c.value = v;
    cmd_q.insert(cmd_q.size(), c);
    if (op == OP_INSERT && gen_fill < DEPTH) begin
      gen_fill++;
    end else if (op == OP_DELETE && gen_fill > 0) begin
      gen_fill--;
    end
  endtask

  task automatic queue_fill_run();
    while (gen_fill < DEPTH) begin
      queue_cmd(OP_INSERT, draw_value());
    end
    // inserts into a full heap
    repeat ($urandom_range(1, 3)) queue_cmd(OP_INSERT, draw_value());
  endtask

  task automatic queue_drain_run();
    while (gen_fill > 0) begin
      queue_cmd(OP_DELETE, value_t'($urandom));
    end
    // deletes on an empty heap
    repeat ($urandom_range(1, 3)) queue_cmd(OP_DELETE, value_t'($urandom));
  endtask

  task automatic queue_mixed_run(int insert_pct);
    repeat (40) begin
      if ($urandom_range(0, 99) < insert_pct) begin
        queue_cmd(OP_INSERT, draw_value());
      end else begin
        queue_cmd(OP_DELETE, value_t'($urandom));
      end
    end
  endtask

  // stimulus, reset and end of run
  initial begin
    // directed: empty delete, extremes, duplicates, drain past empty
    queue_cmd(OP_DELETE, 32'sd0);
    queue_cmd(OP_INSERT, 32'sh7FFF_FFFF);
    queue_cmd(OP_INSERT, 32'sh8000_0000);
    queue_cmd(OP_INSERT, -32'sd1);
    queue_cmd(OP_INSERT, 32'sd0);
    queue_cmd(OP_INSERT, 32'sd5);
    queue_cmd(OP_INSERT, 32'sd5);
    queue_cmd(OP_INSERT, 32'sd5);
    queue_cmd(OP_INSERT, -32'sd1);
    queue_cmd(OP_INSERT, 32'sd3);
    queue_cmd(OP_INSERT, 32'sd7);
    queue_cmd(OP_INSERT, 32'sd7);
    repeat (12) queue_cmd(OP_DELETE, 32'shFFFF_FFFF);
    queue_cmd(OP_DELETE, 32'sh5555_AAAA);

    // random: one guaranteed fill to full, then a mix of run shapes
    queue_fill_run();
    while (cmd_q.size() < ITEM_TARGET) begin
      case ($urandom_range(0, 5))
        0: queue_fill_run();
        1: queue_drain_run();
        2, 3: queue_mixed_run(65);
        default: queue_mixed_run(35);
      endcase
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // wait until every command is sent and every result is checked
    while (cmd_q.size() != 0 || in_tvalid || expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  // input driver: predicts on each accepted transaction, then offers the next
  always @(posedge clk) begin : cmd_driver
    heap_cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_q.insert(expected_q.size(),
                          apply_heap_op(op_t'(in_tuser[0]), value_t'(in_tdata)));
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
          in_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          c = cmd_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= c.value;
          in_tuser <= c.op;
          if (tx_burst_left > 0) begin
            tx_burst_left--;
          end else begin
            tx_gap_left = draw_gap();
            if ($urandom_range(0, 19) == 0) begin
              tx_burst_left = $urandom_range(20, 80);
            end
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold <= 1'b0;
      hold_done <= 1'b0;
      hold_count <= 0;
    end else if (rx_hold) begin
      if (hold_count == HOLD_CYCLES - 1) begin
        rx_hold <= 1'b0;
      end
      hold_count <= hold_count + 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      rx_hold <= 1'b1;
      hold_done <= 1'b1;
      hold_count <= 0;
    end
  end

  // result monitor and ready generator
  always @(posedge clk) begin : result_monitor
    heap_result_t exp_r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction: tdata %h tuser %0d", out_tdata, out_tuser);
          mismatch_count++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_tdata[31:0] !== exp_r.removed) begin
            $error("removed_value: expected %0d, got %0d", exp_r.removed,
                   $signed(out_tdata[31:0]));
            mismatch_count++;
          end
          if (out_tdata[63:32] !== exp_r.top) begin
            $error("top_value: expected %0d, got %0d", exp_r.top, $signed(out_tdata[63:32]));
            mismatch_count++;
          end
          if (out_tdata[72:64] !== exp_r.count) begin
            $error("entry_count: expected %0d, got %0d", exp_r.count, out_tdata[72:64]);
            mismatch_count++;
          end
          if (out_tuser !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_tuser);
            mismatch_count++;
          end
        end
      end
      if (rx_hold) begin
        out_tready <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (rx_burst_left > 0) begin
          rx_burst_left--;
        end else begin
          rx_stall_left = draw_gap();
          if ($urandom_range(0, 19) == 0) begin
            rx_burst_left = $urandom_range(20, 80);
          end
        end
      end
    end
  end

endmodule
